@@ hdl/dspg_pkg.sv @@
// Package for the dual axis step pulse generator: widths, codes,
// register indexes and the item structs. No dependencies.
`timescale 1ns / 1ps

package dspg_pkg;

  localparam int STEP_COUNT_BITS = 16;
  localparam int WAIT_BITS       = 20;
  localparam int CFG_DATA_BITS   = (STEP_COUNT_BITS > WAIT_BITS) ? STEP_COUNT_BITS : WAIT_BITS;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int DIV_CNT_BITS    = $clog2(STEP_COUNT_BITS);

  localparam logic [WAIT_BITS-1:0] HALF_PERIOD_RESET = WAIT_BITS'(1000);

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  localparam logic [2:0] LIMIT_NONE  = 3'd0;
  localparam logic [2:0] LIMIT_UP    = 3'd1;
  localparam logic [2:0] LIMIT_DOWN  = 3'd2;
  localparam logic [2:0] LIMIT_LEFT  = 3'd3;
  localparam logic [2:0] LIMIT_RIGHT = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HORIZ_STEPS  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VERT_STEPS   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HORIZ_DIR    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VERT_DIR     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_PERIOD  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHECK_LIMITS = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic       vert_limit_sensor;
    logic       horiz_limit_sensor;
  } in_item_t;

  typedef struct packed {
    logic       horiz_step_level;
    logic       vert_step_level;
    logic       horiz_dir_level;
    logic       vert_dir_level;
    logic       motors_locked;
    logic       busy_res;
    logic       move_done;
    logic       start_error;
    logic [2:0] limit_hit;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  wdata;
  } cfg_item_t;

  typedef struct packed {
    logic                       done;
    logic [STEP_COUNT_BITS-1:0] quotient;
  } div_res_t;

endpackage

@@ hdl/dspg_if.sv @@
// Valid/ready channel interfaces for input items, result items and
// configuration writes. Depends on dspg_pkg.
`timescale 1ns / 1ps

interface dspg_in_if;
  logic               valid;
  logic               ready;
  dspg_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dspg_out_if;
  logic                valid;
  logic                ready;
  dspg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dspg_cfg_if;
  logic                valid;
  logic                ready;
  dspg_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/dspg_div.sv @@
// Restoring divider, one quotient bit per cycle, for the step ratio.
// Depends on dspg_pkg.
`timescale 1ns / 1ps

module dspg_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [dspg_pkg::STEP_COUNT_BITS-1:0] dividend_i,
  input  logic [dspg_pkg::STEP_COUNT_BITS-1:0] divisor_i,
  output dspg_pkg::div_res_t                   res_o
);
  import dspg_pkg::*;

  localparam int W = STEP_COUNT_BITS;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [W-1:0]            rem_q, rem_d;
  logic [W-1:0]            quo_q, quo_d;
  logic [W-1:0]            dvs_q, dvs_d;
  logic [W:0]              shifted;
  logic [W:0]              diff;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_BITS'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;

endmodule

@@ hdl/dual_axis_step_pulse_generator_core.sv @@
// Two-axis step/direction generator: ticks, stop and move control.
// A tick or stop item gives its registered result in the cycle after it is
// accepted, one item per cycle while the output is not stalled. A start
// from idle runs the ratio divider, with input held off until its result.
// Reset: idle, motors locked, step levels low, registers at their defaults.
// Depends on dspg_pkg, dspg_if and dspg_div.
`timescale 1ns / 1ps

module dual_axis_step_pulse_generator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dspg_in_if.sink    in_i,
  dspg_out_if.source out_o,
  dspg_cfg_if.sink   cfg_i
);
  import dspg_pkg::*;

  localparam int S = STEP_COUNT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [S-1:0]         hsteps_q, vsteps_q;
  logic                 hdir_q, vdir_q, check_q;
  logic [WAIT_BITS-1:0] half_q;

  // move state
  logic                 running_q, running_d;
  logic                 major_h_q, major_h_d;
  logic [S-1:0]         ratio_q, ratio_d;
  logic [S-1:0]         rcnt_q, rcnt_d;
  logic [S-1:0]         iter_q, iter_d;
  logic [S-1:0]         total_q, total_d;
  logic                 phase_q, phase_d;
  logic [WAIT_BITS-1:0] wait_q, wait_d;
  logic                 hlev_q, hlev_d;
  logic                 vlev_q, vlev_d;
  logic [3:0]           latch_q, latch_d;
  logic                 stop_q, stop_d;
  logic                 locked_q, locked_d;
  logic                 mv_hdir_q, mv_hdir_d;
  logic                 mv_vdir_q, mv_vdir_d;
  logic                 mv_check_q, mv_check_d;
  logic [WAIT_BITS-1:0] mv_wait_q, mv_wait_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic         in_acc;
  logic         is_start;
  logic         div_start;
  div_res_t     div_res;
  logic         h_gt_v;
  logic [S-1:0] major, minor;
  logic [S:0]   rcnt_inc;
  logic         done, err;
  logic [2:0]   hit;
  logic         minor_tgl;

  assign in_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_start    = in_i.data.func == FUNC_START;
  assign div_start   = in_acc && !running_q && is_start;
  assign cfg_i.ready = 1'b1;

  assign h_gt_v   = hsteps_q > vsteps_q;
  assign major    = h_gt_v ? hsteps_q : vsteps_q;
  assign minor    = h_gt_v ? vsteps_q : hsteps_q;
  assign rcnt_inc = {1'b0, rcnt_q} + 1'b1;
  assign minor_tgl = rcnt_q == '0;

  dspg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (major),
    .divisor_i  (minor),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsteps_q <= '0;
      vsteps_q <= '0;
      hdir_q   <= 1'b0;
      vdir_q   <= 1'b0;
      half_q   <= HALF_PERIOD_RESET;
      check_q  <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.data.index)
        REG_HORIZ_STEPS:  hsteps_q <= cfg_i.data.wdata[S-1:0];
        REG_VERT_STEPS:   vsteps_q <= cfg_i.data.wdata[S-1:0];
        REG_HORIZ_DIR:    hdir_q   <= cfg_i.data.wdata[0];
        REG_VERT_DIR:     vdir_q   <= cfg_i.data.wdata[0];
        REG_HALF_PERIOD:  half_q   <= cfg_i.data.wdata[WAIT_BITS-1:0];
        REG_CHECK_LIMITS: check_q  <= cfg_i.data.wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    running_d  = running_q;
    major_h_d  = major_h_q;
    ratio_d    = ratio_q;
    rcnt_d     = rcnt_q;
    iter_d     = iter_q;
    total_d    = total_q;
    phase_d    = phase_q;
    wait_d     = wait_q;
    hlev_d     = hlev_q;
    vlev_d     = vlev_q;
    latch_d    = latch_q;
    stop_d     = stop_q;
    locked_d   = locked_q;
    mv_hdir_d  = mv_hdir_q;
    mv_vdir_d  = mv_vdir_q;
    mv_check_d = mv_check_q;
    mv_wait_d  = mv_wait_q;
    done       = 1'b0;
    err        = 1'b0;
    hit        = LIMIT_NONE;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          state_d = ST_DIV;
        end else if (in_acc) begin
          out_valid_d = 1'b1;
          if (running_q) begin
            if (in_i.data.func == FUNC_STOP) begin
              stop_d = 1'b1;
            end
            if (wait_q != '0) begin
              wait_d = wait_q - 1'b1;
            end else if (!phase_q) begin
              if (stop_d || iter_q >= total_q) begin
                done = 1'b1;
              end else begin
                if (mv_check_q) begin
                  // vertical switch first, horizontal only when no vertical hit
                  if (in_i.data.vert_limit_sensor) begin
                    if (!mv_vdir_q) begin
                      if (!latch_q[1]) begin
                        latch_d[0] = 1'b1;
                        hit = LIMIT_UP;
                      end
                    end else if (!latch_q[0]) begin
                      latch_d[1] = 1'b1;
                      hit = LIMIT_DOWN;
                    end
                  end else begin
                    latch_d[1:0] = 2'b00;
                  end
                  if (hit == LIMIT_NONE) begin
                    if (in_i.data.horiz_limit_sensor) begin
                      if (!mv_hdir_q) begin
                        if (!latch_q[3]) begin
                          latch_d[2] = 1'b1;
                          hit = LIMIT_LEFT;
                        end
                      end else if (!latch_q[2]) begin
                        latch_d[3] = 1'b1;
                        hit = LIMIT_RIGHT;
                      end
                    end else begin
                      latch_d[3:2] = 2'b00;
                    end
                  end
                end
                if (hit != LIMIT_NONE) begin
                  done = 1'b1;
                end else begin
                  phase_d = 1'b1;
                end
              end
            end else begin
              phase_d = 1'b0;
              iter_d  = iter_q + 1'b1;
            end
            // half-step on either phase
            if (wait_q == '0 && !done) begin
              if (major_h_q) begin
                hlev_d = !hlev_q;
                if (minor_tgl) vlev_d = !vlev_q;
              end else begin
                vlev_d = !vlev_q;
                if (minor_tgl) hlev_d = !hlev_q;
              end
              rcnt_d = (rcnt_inc >= {1'b0, ratio_q}) ? '0 : rcnt_inc[S-1:0];
              wait_d = mv_wait_q;
            end
            if (done) begin
              running_d = 1'b0;
              locked_d  = 1'b1;
              stop_d    = 1'b0;
              wait_d    = '0;
              phase_d   = 1'b0;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (minor == '0 || (div_res.quotient != S'(1) && div_res.quotient[0])) begin
            err = 1'b1;
          end else begin
            major_h_d  = h_gt_v;
            ratio_d    = div_res.quotient;
            rcnt_d     = '0;
            iter_d     = '0;
            total_d    = major;
            phase_d    = 1'b0;
            wait_d     = '0;
            hlev_d     = 1'b0;
            vlev_d     = 1'b0;
            stop_d     = 1'b0;
            locked_d   = 1'b0;
            mv_hdir_d  = hdir_q;
            mv_vdir_d  = vdir_q;
            mv_check_d = check_q;
            mv_wait_d  = half_q;
            running_d  = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_d.horiz_step_level = hlev_d;
    out_d.vert_step_level  = vlev_d;
    out_d.horiz_dir_level  = mv_hdir_d;
    out_d.vert_dir_level   = mv_vdir_d;
    out_d.motors_locked    = locked_d;
    out_d.busy_res         = running_d;
    out_d.move_done        = done;
    out_d.start_error      = err;
    out_d.limit_hit        = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      major_h_q   <= 1'b0;
      ratio_q     <= '0;
      rcnt_q      <= '0;
      iter_q      <= '0;
      total_q     <= '0;
      phase_q     <= 1'b0;
      wait_q      <= '0;
      hlev_q      <= 1'b0;
      vlev_q      <= 1'b0;
      latch_q     <= '0;
      stop_q      <= 1'b0;
      locked_q    <= 1'b1;
      mv_hdir_q   <= 1'b0;
      mv_vdir_q   <= 1'b0;
      mv_check_q  <= 1'b0;
      mv_wait_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      major_h_q   <= major_h_d;
      ratio_q     <= ratio_d;
      rcnt_q      <= rcnt_d;
      iter_q      <= iter_d;
      total_q     <= total_d;
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      hlev_q      <= hlev_d;
      vlev_q      <= vlev_d;
      latch_q     <= latch_d;
      stop_q      <= stop_d;
      locked_q    <= locked_d;
      mv_hdir_q   <= mv_hdir_d;
      mv_vdir_q   <= mv_vdir_d;
      mv_check_q  <= mv_check_d;
      mv_wait_q   <= mv_wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_d && (!out_valid_q || out_o.ready)) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

@@ hdl/dspg_checker.sv @@
// Port-level checks on result items of the step generator, bound to the
// top level. Depends on dspg_pkg and dual_axis_step_pulse_generator_core.
`timescale 1ns / 1ps

module dspg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input dspg_pkg::out_item_t out_data_i
);
  import dspg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result item dropped or changed while stalled");

  a_done_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.move_done |-> !out_data_i.busy_res && out_data_i.motors_locked)
    else $error("move ended without locking the motors");

  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.start_error |->
      !out_data_i.busy_res && !out_data_i.move_done && out_data_i.motors_locked)
    else $error("rejected start left a move running");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.limit_hit != LIMIT_NONE |-> out_data_i.move_done)
    else $error("limit hit reported without ending the move");

endmodule

bind dual_axis_step_pulse_generator_core dspg_checker u_dspg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
